FILE: rtl/greedy_least_loaded_task_assigner_core_macros.svh
// ----------------------------------------------------------------------------
// Greedy least-loaded task assigner: assertion macros
// Shared assertion helpers for the assigner RTL.
// ----------------------------------------------------------------------------
`ifndef GREEDY_LEAST_LOADED_TASK_ASSIGNER_CORE_MACROS_SVH
`define GREEDY_LEAST_LOADED_TASK_ASSIGNER_CORE_MACROS_SVH

`ifndef SYNTH
// Checked outside reset.
`define GLTA_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// Checked on every edge, reset included.
`define GLTA_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define GLTA_ASSERT(lbl, ck, rstn, prop, msg)
`define GLTA_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

FILE: rtl/glta_pkg.sv
// ----------------------------------------------------------------------------
// Greedy least-loaded task assigner: package
// Fixed field widths, register indexes and the task class word.
// ----------------------------------------------------------------------------
`default_nettype none

package glta_pkg;

  localparam int TASK_LOAD_W = 32;
  localparam int TOTAL_W     = 40;
  localparam int CHOSEN_W    = 4;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TOTAL_W-1:0]   TOTAL_MAX      = '1;
  localparam logic [COUNT_W-1:0]   COUNT_RESET    = 5'd16;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_CNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TOL   = 2'd1;

  typedef struct packed {
    logic batch_start;
    logic no_workers;
    logic below_tol;
  } cls_t;

endpackage

`default_nettype wire

FILE: rtl/greedy_least_loaded_task_assigner_core.sv
// ----------------------------------------------------------------------------
// Greedy least-loaded task assigner core
// Gives each assigned task to the worker with the smallest running total.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Fields
// in_      input      in_push / in_full  in_task_load, in_batch_start
// out_     output     out_empty/out_pop  out_assigned, out_chosen_worker,
//                                        out_worker_total
// cfg_     input      cfg_valid/ready    cfg_index, cfg_data
//
// An assigned task is scanned in S_SCAN, which reads the totals memory one entry
// per cycle over the N active workers, then updated in S_UPD and held in S_DONE.
// An unassigned task goes from S_IDLE straight to S_DONE.
// A two-entry queue lets the input accept words while the engine is busy.
// Reset clears totals through per-worker valid bits, so no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_least_loaded_task_assigner_core #(
  parameter int MAX_WORKERS = 16,
  parameter int LOAD_BITS   = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [glta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [glta_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [glta_pkg::TASK_LOAD_W-1:0] in_task_load,
  input  wire logic                             in_batch_start,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic                                  out_assigned,
  output logic [glta_pkg::CHOSEN_W-1:0]         out_chosen_worker,
  output logic [glta_pkg::TOTAL_W-1:0]          out_worker_total
);

  localparam int LW    = (LOAD_BITS < glta_pkg::TASK_LOAD_W) ? LOAD_BITS
                                                             : glta_pkg::TASK_LOAD_W;
  localparam int IDX_W = $clog2(MAX_WORKERS);
  localparam int W     = LW + IDX_W + $bits(glta_pkg::cls_t);

  logic         q_push;
  logic [W-1:0] q_wdata;
  logic         q_full;
  logic         q_pop;
  logic [W-1:0] q_rdata;
  logic         q_empty;

  glta_front #(
    .MAX_WORKERS(MAX_WORKERS),
    .LOAD_BITS  (LOAD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_task_load  (in_task_load),
    .in_batch_start(in_batch_start),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  glta_queue #(
    .W(W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  glta_back #(
    .MAX_WORKERS(MAX_WORKERS),
    .LOAD_BITS  (LOAD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (q_rdata),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_assigned     (out_assigned),
    .out_chosen_worker(out_chosen_worker),
    .out_worker_total (out_worker_total)
  );

endmodule

`default_nettype wire

FILE: rtl/glta_front.sv
// ----------------------------------------------------------------------------
// Greedy least-loaded task assigner: front end
// Holds the configuration registers, accepts task words and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module glta_front #(
  parameter int MAX_WORKERS = 16,
  parameter int LOAD_BITS   = 32,
  localparam int LW    = (LOAD_BITS < glta_pkg::TASK_LOAD_W) ? LOAD_BITS : glta_pkg::TASK_LOAD_W,
  localparam int IDX_W = $clog2(MAX_WORKERS),
  localparam int W     = LW + IDX_W + $bits(glta_pkg::cls_t)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [glta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [glta_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [glta_pkg::TASK_LOAD_W-1:0] in_task_load,
  input  wire logic                            in_batch_start,
  output logic                                 q_push,
  output logic [W-1:0]                         q_data,
  input  wire logic                            q_full
);

  logic [glta_pkg::COUNT_W-1:0]    count_r;
  logic [glta_pkg::CFG_DATA_W-1:0] tol_r;
  logic [LW-1:0]                   load;
  logic [IDX_W-1:0]                last_idx;
  glta_pkg::cls_t                  cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= glta_pkg::COUNT_RESET;
      tol_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        glta_pkg::CFG_WORKER_CNT: begin
          count_r <= cfg_data[glta_pkg::COUNT_W-1:0];
        end
        glta_pkg::CFG_LOAD_TOL: begin
          tol_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    load = in_task_load[LW-1:0];
    if (32'(count_r) > 32'(MAX_WORKERS)) begin
      last_idx = IDX_W'(MAX_WORKERS - 1);
    end else begin
      last_idx = IDX_W'(32'(count_r) - 32'd1);
    end
    cls.batch_start = in_batch_start;
    cls.no_workers  = (count_r == '0);
    cls.below_tol   = (32'(load) <= tol_r);
  end

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign q_push    = in_push && !q_full;
  assign q_data    = {load, last_idx, cls};

endmodule

`default_nettype wire

FILE: rtl/glta_queue.sv
// ----------------------------------------------------------------------------
// Greedy least-loaded task assigner: task queue
// Two-entry queue that decouples the front end from the scan engine.
// ----------------------------------------------------------------------------
`default_nettype none

module glta_queue #(
  parameter int W = 39
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  logic [W-1:0] ent_r [2];
  logic         wptr_r;
  logic         rptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glta_back.sv
// ----------------------------------------------------------------------------
// Greedy least-loaded task assigner: scan engine
// For an assigned task finds and updates the least total; emits every result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "greedy_least_loaded_task_assigner_core_macros.svh"

module glta_back #(
  parameter int MAX_WORKERS = 16,
  parameter int LOAD_BITS   = 32,
  localparam int LW    = (LOAD_BITS < glta_pkg::TASK_LOAD_W) ? LOAD_BITS : glta_pkg::TASK_LOAD_W,
  localparam int IDX_W = $clog2(MAX_WORKERS),
  localparam int W     = LW + IDX_W + $bits(glta_pkg::cls_t),
  localparam int SUM_W = glta_pkg::TOTAL_W + 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [W-1:0]                      q_data,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic                                   out_assigned,
  output logic [glta_pkg::CHOSEN_W-1:0]          out_chosen_worker,
  output logic [glta_pkg::TOTAL_W-1:0]           out_worker_total
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD, S_DONE} state_t;

  state_t                       st_r;
  logic [glta_pkg::TOTAL_W-1:0] mem [MAX_WORKERS];
  logic [glta_pkg::TOTAL_W-1:0] rd_data_r;
  logic [MAX_WORKERS-1:0]       valid_r;
  logic                         cut_r;
  logic [LW-1:0]                load_r;
  logic [IDX_W-1:0]             last_r;
  logic [IDX_W-1:0]             rd_addr_r;
  logic                         issue_r;
  logic                         cmp_go_r;
  logic [IDX_W-1:0]             cmp_idx_r;
  logic [glta_pkg::TOTAL_W-1:0] best_val_r;
  logic [IDX_W-1:0]             best_idx_r;
  logic                         res_assigned_r;
  logic [glta_pkg::CHOSEN_W-1:0] res_chosen_r;
  logic [glta_pkg::TOTAL_W-1:0] res_total_r;
  logic                         out_vld_r;
  logic                         out_asg_r;
  logic [glta_pkg::CHOSEN_W-1:0] out_chosen_r;
  logic [glta_pkg::TOTAL_W-1:0] out_total_r;

  logic [LW-1:0]                q_load;
  logic [IDX_W-1:0]             q_last;
  glta_pkg::cls_t               q_cls;
  logic                         eff_cut;
  logic [glta_pkg::TOTAL_W-1:0] cmp_val;
  logic [SUM_W-1:0]             sum;
  logic [glta_pkg::TOTAL_W-1:0] sum_sat;
  logic                         wr_en;

  assign {q_load, q_last, q_cls} = q_data;
  assign q_pop   = (st_r == S_IDLE) && !q_empty;
  assign eff_cut = q_cls.batch_start ? 1'b0 : cut_r;
  assign cmp_val = valid_r[cmp_idx_r] ? rd_data_r : '0;
  assign sum     = SUM_W'(best_val_r) + SUM_W'(load_r);
  assign sum_sat = sum[glta_pkg::TOTAL_W] ? glta_pkg::TOTAL_MAX
                                           : sum[glta_pkg::TOTAL_W-1:0];
  assign wr_en   = (st_r == S_UPD);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[best_idx_r] <= sum_sat;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      valid_r   <= '0;
      cut_r     <= 1'b0;
      issue_r   <= 1'b0;
      cmp_go_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (st_r == S_DONE && (!out_vld_r || out_pop)) begin
        out_vld_r <= 1'b1;
      end else if (out_pop && out_vld_r) begin
        out_vld_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_cls.batch_start) begin
              valid_r <= '0;
            end
            res_assigned_r <= 1'b0;
            res_chosen_r   <= '0;
            res_total_r    <= '0;
            load_r         <= q_load;
            last_r         <= q_last;
            priority if (q_cls.no_workers || eff_cut) begin
              cut_r <= eff_cut;
              st_r  <= S_DONE;
            end else if (q_cls.below_tol) begin
              cut_r <= 1'b1;
              st_r  <= S_DONE;
            end else begin
              cut_r     <= eff_cut;
              rd_addr_r <= '0;
              issue_r   <= 1'b1;
              cmp_go_r  <= 1'b0;
              st_r      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue_r) begin
            cmp_go_r  <= 1'b1;
            cmp_idx_r <= rd_addr_r;
            if (rd_addr_r == last_r) begin
              issue_r <= 1'b0;
            end else begin
              rd_addr_r <= rd_addr_r + IDX_W'(1);
            end
          end else begin
            cmp_go_r <= 1'b0;
          end
          if (cmp_go_r) begin
            if (cmp_idx_r == '0 || cmp_val < best_val_r) begin
              best_val_r <= cmp_val;
              best_idx_r <= cmp_idx_r;
            end
            if (cmp_idx_r == last_r) begin
              st_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          valid_r[best_idx_r] <= 1'b1;
          res_assigned_r      <= 1'b1;
          res_chosen_r        <= glta_pkg::CHOSEN_W'(best_idx_r);
          res_total_r         <= sum_sat;
          cmp_go_r            <= 1'b0;
          st_r                <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_r || out_pop) begin
            out_asg_r    <= res_assigned_r;
            out_chosen_r <= res_chosen_r;
            out_total_r  <= res_total_r;
            st_r         <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_empty         = !out_vld_r;
  assign out_assigned      = out_asg_r;
  assign out_chosen_worker = out_chosen_r;
  assign out_worker_total  = out_total_r;

  `GLTA_ASSERT(a_cmp_in_range, clk, rst_n, cmp_go_r |-> (cmp_idx_r <= last_r), "scan index past last worker")
  `GLTA_ASSERT(a_best_in_range, clk, rst_n, (st_r == S_UPD) |-> (best_idx_r <= last_r), "chosen worker outside active range")
  `GLTA_ASSERT(a_done_holds, clk, rst_n, (st_r == S_DONE && out_vld_r && !out_pop) |=> (st_r == S_DONE), "result dropped while output full")
  `GLTA_ASSERT(a_batch_clears, clk, rst_n, (st_r == S_IDLE && !q_empty && q_cls.batch_start) |=> (valid_r == '0), "batch start did not clear totals")
  `GLTA_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty, "output not empty after reset")

endmodule

`default_nettype wire
